### hdl/mfs_pkg.sv
// Shared widths, register indexes, sequencer steps and the control store of the scheduler.
package mfs_pkg;

	localparam int SLOT_W    = 3;
	localparam int WORK_W    = 16;
	localparam int LEVEL_W   = 2;
	localparam int TIME_W    = 32;
	localparam int QUANT_W   = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TOP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_MIDDLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_BOTTOM = 2'd2;

	// input operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [QUANT_W-1:0] QUANTUM_TOP_RST    = 16'd10;
	localparam logic [QUANT_W-1:0] QUANTUM_MIDDLE_RST = 16'd20;
	localparam logic [QUANT_W-1:0] QUANTUM_BOTTOM_RST = 16'd40;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INIT,
		ST_SCAN,
		ST_TEST,
		ST_EMPTY,
		ST_CALC,
		ST_COMMIT,
		ST_LOAD
	} step_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_IN_FIRE,
		C_OP_LOAD,
		C_SCAN_END,
		C_FOUND,
		C_OUT_FREE
	} cond_t;

	// one control word: datapath actions, jump condition and both successors
	typedef struct packed {
		logic  take_in;
		logic  load;
		logic  scan_init;
		logic  scan_go;
		logic  calc;
		logic  commit;
		logic  emit_empty;
		cond_t cond;
		step_t on_true;
		step_t on_false;
	} ucode_t;

	// control store
	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		w          = '0;
		w.cond     = C_ALWAYS;
		w.on_true  = ST_IDLE;
		w.on_false = ST_IDLE;
		case (s)
			ST_IDLE: begin
				w.take_in  = 1'b1;
				w.cond     = C_IN_FIRE;
				w.on_true  = ST_DISPATCH;
				w.on_false = ST_IDLE;
			end
			ST_DISPATCH: begin
				w.cond     = C_OP_LOAD;
				w.on_true  = ST_LOAD;
				w.on_false = ST_INIT;
			end
			ST_INIT: begin
				w.scan_init = 1'b1;
				w.cond      = C_ALWAYS;
				w.on_true   = ST_SCAN;
				w.on_false  = ST_SCAN;
			end
			ST_SCAN: begin
				w.scan_go  = 1'b1;
				w.cond     = C_SCAN_END;
				w.on_true  = ST_TEST;
				w.on_false = ST_SCAN;
			end
			ST_TEST: begin
				w.cond     = C_FOUND;
				w.on_true  = ST_CALC;
				w.on_false = ST_EMPTY;
			end
			ST_EMPTY: begin
				w.emit_empty = 1'b1;
				w.cond       = C_OUT_FREE;
				w.on_true    = ST_IDLE;
				w.on_false   = ST_EMPTY;
			end
			ST_CALC: begin
				w.calc     = 1'b1;
				w.cond     = C_ALWAYS;
				w.on_true  = ST_COMMIT;
				w.on_false = ST_COMMIT;
			end
			ST_COMMIT: begin
				w.commit   = 1'b1;
				w.cond     = C_OUT_FREE;
				w.on_true  = ST_IDLE;
				w.on_false = ST_COMMIT;
			end
			ST_LOAD: begin
				w.load     = 1'b1;
				w.cond     = C_ALWAYS;
				w.on_true  = ST_IDLE;
				w.on_false = ST_IDLE;
			end
			default: begin
				w.cond     = C_ALWAYS;
				w.on_true  = ST_IDLE;
				w.on_false = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

### hdl/mfs_ram.sv
// Generic single write port RAM with one registered read port.
module mfs_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/multilevel_feedback_scheduler.sv
// Three-level feedback queue scheduler: microcoded sequencer over a slot RAM.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid / in_stall | op, slot, burst
//  out     | out_valid/out_stall | slot_id, run_units, remaining_after, completed,
//          |                     | level_run, elapsed, all_done
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (quantum registers)
//
//  A load passes through the accepting idle step, dispatch and the RAM write.
//  A step scans one slot per cycle through the slot RAM read port, making at most
//  NUM_LEVELS+1 passes over the slots.
//  Slot state is cleared at once by reset through per-slot valid flops; no clearing pass.
//  in_stall is low only while the sequencer is idle; a held result (out_stall high)
//  keeps the sequencer waiting at its commit or empty step, and no transaction is taken.
//  cfg_ready is always high.
module multilevel_feedback_scheduler #(
	parameter int NUM_SLOTS  = 8,
	parameter int NUM_LEVELS = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [mfs_pkg::SLOT_W-1:0]      slot,
	input  logic [mfs_pkg::WORK_W-1:0]      burst,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mfs_pkg::SLOT_W-1:0]      slot_id,
	output logic [mfs_pkg::WORK_W-1:0]      run_units,
	output logic [mfs_pkg::WORK_W-1:0]      remaining_after,
	output logic                            completed,
	output logic [mfs_pkg::LEVEL_W-1:0]     level_run,
	output logic [mfs_pkg::TIME_W-1:0]      elapsed,
	output logic                            all_done,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mfs_pkg::QUANT_W-1:0]     cfg_data
);

	import mfs_pkg::*;

	localparam int PTR_W  = $clog2(NUM_SLOTS);
	localparam int PASS_W = $clog2(NUM_LEVELS + 2);
	localparam int ENT_W  = LEVEL_W + WORK_W;

	localparam logic [PTR_W-1:0]   LAST_SLOT  = PTR_W'(NUM_SLOTS - 1);
	localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(NUM_LEVELS - 1);
	localparam logic [PASS_W-1:0]  LAST_PASS  = PASS_W'(NUM_LEVELS);

	// sequencer
	step_t  step_q, step_d;
	ucode_t cw;
	logic   cond_true;

	// configuration
	logic [QUANT_W-1:0] quantum_top_q, quantum_middle_q, quantum_bottom_q;

	// latched input transaction
	logic              op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [WORK_W-1:0] burst_q;

	// scheduler state
	logic [NUM_SLOTS-1:0] valid_q;
	logic [LEVEL_W-1:0]   current_level_q;
	logic [PTR_W-1:0]     scan_pointer_q;
	logic [TIME_W-1:0]    time_total_q;

	// scan
	logic [PTR_W-1:0]   idx_q;
	logic [PTR_W-1:0]   pos_q;
	logic [LEVEL_W-1:0] scan_lvl_q;
	logic [PASS_W-1:0]  pass_q;
	logic               rd_vld_s1;
	logic               rd_ok_s1;
	logic [PTR_W-1:0]   rd_idx_s1;
	logic [LEVEL_W-1:0] rd_lvl_s1;
	logic [ENT_W-1:0]   rd_data;
	logic [WORK_W-1:0]  ent_rem;
	logic [LEVEL_W-1:0] ent_lvl;
	logic               can_issue, issue, hit, scan_end;

	// pick and slice
	logic               found_q;
	logic [PTR_W-1:0]   pick_q;
	logic [WORK_W-1:0]  pick_rem_q;
	logic [LEVEL_W-1:0] pick_lvl_q;
	logic [QUANT_W-1:0] quantum_sel, quantum_eff;
	logic [WORK_W-1:0]  run_q, after_q;
	logic [LEVEL_W-1:0] new_lvl_q;
	logic [TIME_W:0]    time_sum;
	logic [TIME_W-1:0]  time_next;

	// RAM write side
	logic               load_wr, commit_en, emit_en, out_free, in_fire, cfg_fire;
	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [ENT_W-1:0]   ram_wdata;

	// output register
	logic                out_valid_q;
	logic [SLOT_W-1:0]   slot_id_q;
	logic [WORK_W-1:0]   run_units_q, remaining_after_q;
	logic                completed_q, all_done_q;
	logic [LEVEL_W-1:0]  level_run_q;
	logic [TIME_W-1:0]   elapsed_q;

	// handshakes
	assign in_stall  = ~cw.take_in;
	assign in_fire   = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	// decode the current control word
	always_comb begin
		cw = ucode_rom(step_q);
	end

	// evaluate the jump condition and pick the next step
	always_comb begin
		case (cw.cond)
			C_NEVER:    cond_true = 1'b0;
			C_ALWAYS:   cond_true = 1'b1;
			C_IN_FIRE:  cond_true = in_fire;
			C_OP_LOAD:  cond_true = (op_q == OP_LOAD);
			C_SCAN_END: cond_true = scan_end;
			C_FOUND:    cond_true = found_q;
			C_OUT_FREE: cond_true = out_free;
			default:    cond_true = 1'b0;
		endcase
		step_d = cond_true ? cw.on_true : cw.on_false;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// quantum registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_top_q    <= QUANTUM_TOP_RST;
			quantum_middle_q <= QUANTUM_MIDDLE_RST;
			quantum_bottom_q <= QUANTUM_BOTTOM_RST;
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_QUANTUM_TOP:    quantum_top_q    <= cfg_data;
				CFG_QUANTUM_MIDDLE: quantum_middle_q <= cfg_data;
				CFG_QUANTUM_BOTTOM: quantum_bottom_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// latch the accepted transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q    <= op;
			slot_q  <= slot;
			burst_q <= burst;
		end
	end

	// scan issue and evaluation
	assign can_issue = (pass_q <= LAST_PASS);
	assign ent_rem   = rd_ok_s1 ? rd_data[WORK_W-1:0] : '0;
	assign ent_lvl   = rd_ok_s1 ? rd_data[ENT_W-1:WORK_W] : '0;
	assign hit       = cw.scan_go & rd_vld_s1 & (ent_rem != '0) & (ent_lvl == rd_lvl_s1);
	assign issue     = cw.scan_go & ~hit & can_issue;
	assign scan_end  = hit | (~can_issue & ~rd_vld_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cw.scan_init) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	// advance the scan position, moving to the next level after a full pass
	always_ff @(posedge clk) begin
		if (cw.scan_init) begin
			idx_q      <= scan_pointer_q;
			scan_lvl_q <= current_level_q;
			pos_q      <= '0;
			pass_q     <= '0;
		end else if (issue) begin
			if (pos_q == LAST_SLOT) begin
				pos_q      <= '0;
				idx_q      <= '0;
				scan_lvl_q <= (scan_lvl_q == LAST_LEVEL) ? '0 : scan_lvl_q + 1'b1;
				pass_q     <= pass_q + 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
				idx_q <= (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
			end
		end
		rd_idx_s1 <= idx_q;
		rd_lvl_s1 <= scan_lvl_q;
		rd_ok_s1  <= valid_q[idx_q];
		if (hit) begin
			pick_q     <= rd_idx_s1;
			pick_rem_q <= ent_rem;
			pick_lvl_q <= rd_lvl_s1;
		end
	end

	// quantum of the picked level; zero acts as one
	always_comb begin
		if (pick_lvl_q >= LAST_LEVEL) begin
			quantum_sel = quantum_bottom_q;
		end else if (pick_lvl_q == '0) begin
			quantum_sel = quantum_top_q;
		end else begin
			quantum_sel = quantum_middle_q;
		end
		quantum_eff = (quantum_sel == '0) ? QUANT_W'(1) : quantum_sel;
	end

	// compute the slice and the demotion
	always_ff @(posedge clk) begin
		if (cw.calc) begin
			if (pick_rem_q <= quantum_eff) begin
				run_q     <= pick_rem_q;
				after_q   <= '0;
				new_lvl_q <= pick_lvl_q;
			end else begin
				run_q     <= quantum_eff;
				after_q   <= pick_rem_q - quantum_eff;
				new_lvl_q <= (pick_lvl_q < LAST_LEVEL) ? pick_lvl_q + 1'b1 : pick_lvl_q;
			end
		end
	end

	// saturating elapsed time
	assign time_sum  = {1'b0, time_total_q} + (TIME_W + 1)'(run_q);
	assign time_next = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

	assign commit_en = cw.commit & out_free;
	assign emit_en   = cw.emit_empty & out_free;
	assign load_wr   = cw.load & (32'(slot_q) < NUM_SLOTS);

	// slot RAM write: a load or the committed slice
	always_comb begin
		ram_we    = load_wr | commit_en;
		ram_waddr = commit_en ? pick_q : PTR_W'(slot_q);
		ram_wdata = commit_en ? {new_lvl_q, after_q} : {LEVEL_W'(0), burst_q};
	end

	mfs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// per-slot valid flags, level, pointer and time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q         <= '0;
			current_level_q <= '0;
			scan_pointer_q  <= '0;
			time_total_q    <= '0;
		end else begin
			if (load_wr) begin
				valid_q[PTR_W'(slot_q)] <= 1'b1;
			end
			if (commit_en) begin
				current_level_q <= pick_lvl_q;
				scan_pointer_q  <= (pick_q == LAST_SLOT) ? '0 : pick_q + 1'b1;
				time_total_q    <= time_next;
			end
		end
	end

	// output register: load on a result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit_en || emit_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			slot_id_q         <= SLOT_W'(pick_q);
			run_units_q       <= run_q;
			remaining_after_q <= after_q;
			completed_q       <= (after_q == '0);
			level_run_q       <= pick_lvl_q;
			elapsed_q         <= time_next;
			all_done_q        <= 1'b0;
		end else if (emit_en) begin
			slot_id_q         <= '0;
			run_units_q       <= '0;
			remaining_after_q <= '0;
			completed_q       <= 1'b0;
			level_run_q       <= '0;
			elapsed_q         <= '0;
			all_done_q        <= 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign slot_id         = slot_id_q;
	assign run_units       = run_units_q;
	assign remaining_after = remaining_after_q;
	assign completed       = completed_q;
	assign level_run       = level_run_q;
	assign elapsed         = elapsed_q;
	assign all_done        = all_done_q;

	// a new result appears only from the commit or empty step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(step_q) == ST_COMMIT || $past(step_q) == ST_EMPTY))
		else $error("result appeared outside commit or empty step");

	// an empty result carries no slice
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && all_done) |-> (run_units == '0 && remaining_after == '0 &&
		slot_id == '0 && !completed && elapsed == '0 && level_run == '0))
		else $error("all_done result carries slice data");

	// a real slice runs at least one unit and flags completion exactly when nothing is left
	a_slice_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !all_done) |-> (run_units != '0 &&
		completed == (remaining_after == '0)))
		else $error("inconsistent slice result");

	// the scan never reads past the last slot, and the level stays in range
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (idx_q <= LAST_SLOT && scan_lvl_q <= LAST_LEVEL))
		else $error("scan out of range");

	// input is taken only while the sequencer is idle
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (step_q == ST_DISPATCH))
		else $error("accepted transaction not dispatched");

endmodule

### test/mfs_slice_checker.sv
// Watches the scheduler channels, predicts every slice and compares each result against it.
module mfs_slice_checker #(
	parameter int NUM_SLOTS  = 8,
	parameter int NUM_LEVELS = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            op,
	input  logic [mfs_pkg::SLOT_W-1:0]      slot,
	input  logic [mfs_pkg::WORK_W-1:0]      burst,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [mfs_pkg::SLOT_W-1:0]      slot_id,
	input  logic [mfs_pkg::WORK_W-1:0]      run_units,
	input  logic [mfs_pkg::WORK_W-1:0]      remaining_after,
	input  logic                            completed,
	input  logic [mfs_pkg::LEVEL_W-1:0]     level_run,
	input  logic [mfs_pkg::TIME_W-1:0]      elapsed,
	input  logic                            all_done,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mfs_pkg::QUANT_W-1:0]     cfg_data,
	output int                              error_count,
	output int                              open_count
);
	import mfs_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot_id;
		logic [WORK_W-1:0]  run_units;
		logic [WORK_W-1:0]  remaining_after;
		logic               completed;
		logic [LEVEL_W-1:0] level_run;
		logic [TIME_W-1:0]  elapsed;
		logic               all_done;
	} slice_t;

	// shadow copy of the scheduler state
	logic [WORK_W-1:0]  work_left [NUM_SLOTS];
	logic [LEVEL_W-1:0] slot_tier [NUM_SLOTS];
	int unsigned        active_level;
	int unsigned        scan_from;
	logic [TIME_W-1:0]  busy_time;
	logic [QUANT_W-1:0] q_top;
	logic [QUANT_W-1:0] q_middle;
	logic [QUANT_W-1:0] q_bottom;

	slice_t pending_slices[$];
	int     mismatches = 0;
	int     waiting = 0;

	assign error_count = mismatches;
	assign open_count  = waiting;

	task automatic report_mismatch(string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, longint got, longint want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// a register holding zero grants one unit; the last level takes the bottom quantum
	function automatic int unsigned quantum_for(int unsigned lvl);
		logic [QUANT_W-1:0] q;
		if (lvl >= NUM_LEVELS - 1)
			q = q_bottom;
		else if (lvl == 0)
			q = q_top;
		else
			q = q_middle;
		return (q == 0) ? 1 : q;
	endfunction

	// pick the next slot, run it for up to one quantum and advance the shadow state
	function automatic slice_t next_slice();
		slice_t             r;
		bit                 any;
		bit                 found;
		int unsigned        lvl;
		int unsigned        ptr;
		int unsigned        pick;
		int unsigned        idx;
		int unsigned        q;
		int unsigned        run;
		int                 t;
		int                 k;
		logic [WORK_W-1:0]  rem;
		logic [TIME_W:0]    sum;
		r     = '0;
		any   = 0;
		found = 0;
		pick  = 0;
		for (k = 0; k < NUM_SLOTS; k++)
			if (work_left[k] != 0)
				any = 1;
		lvl = (active_level < NUM_LEVELS) ? active_level : 0;
		ptr = (scan_from < NUM_SLOTS) ? scan_from : 0;
		for (t = 0; any && !found && t <= NUM_LEVELS; t++) begin
			for (k = 0; k < NUM_SLOTS && !found; k++) begin
				idx = (ptr + k) % NUM_SLOTS;
				if (work_left[idx] != 0 && slot_tier[idx] == lvl) begin
					pick  = idx;
					found = 1;
				end
			end
			if (!found) begin
				lvl = (lvl + 1) % NUM_LEVELS;
				ptr = 0;
			end
		end
		if (!found) begin
			r.all_done = 1'b1;
			return r;
		end
		active_level = lvl;
		scan_from    = (pick + 1) % NUM_SLOTS;
		q   = quantum_for(lvl);
		rem = work_left[pick];
		if (rem <= q) begin
			run = 32'(rem);
			rem = '0;
		end else begin
			run = q;
			rem = rem - WORK_W'(q);
			if (lvl < NUM_LEVELS - 1)
				slot_tier[pick] = LEVEL_W'(lvl + 1);
		end
		work_left[pick] = rem;
		// saturate the running total
		sum       = {1'b0, busy_time} + run;
		busy_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		r.slot_id         = SLOT_W'(pick);
		r.run_units       = WORK_W'(run);
		r.remaining_after = rem;
		r.completed       = (rem == 0);
		r.level_run       = LEVEL_W'(lvl);
		r.elapsed         = busy_time;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slice_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				work_left[i] = '0;
				slot_tier[i] = '0;
			end
			active_level = 0;
			scan_from    = 0;
			busy_time    = '0;
			q_top        = QUANTUM_TOP_RST;
			q_middle     = QUANTUM_MIDDLE_RST;
			q_bottom     = QUANTUM_BOTTOM_RST;
			pending_slices.delete();
			waiting = 0;
		end else begin
			// compare the result transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				if (pending_slices.size() == 0) begin
					report_mismatch($sformatf("unexpected result slot_id %0d all_done %0b",
						slot_id, all_done));
				end else begin
					want = pending_slices.pop_front();
					check_field("slot_id", slot_id, want.slot_id);
					check_field("run_units", run_units, want.run_units);
					check_field("remaining_after", remaining_after, want.remaining_after);
					check_field("completed", completed, want.completed);
					check_field("level_run", level_run, want.level_run);
					check_field("elapsed", elapsed, want.elapsed);
					check_field("all_done", all_done, want.all_done);
				end
			end
			// track quantum register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_QUANTUM_TOP: begin
						q_top = cfg_data;
					end
					CFG_QUANTUM_MIDDLE: begin
						q_middle = cfg_data;
					end
					CFG_QUANTUM_BOTTOM: begin
						q_bottom = cfg_data;
					end
					default: begin
					end
				endcase
			end
			// apply the input transaction in acceptance order
			if (in_valid && !in_stall) begin
				if (op == OP_LOAD) begin
					if (slot < NUM_SLOTS) begin
						work_left[slot] = burst;
						slot_tier[slot] = '0;
					end
				end else begin
					pending_slices.push_back(next_slice());
				end
			end
			waiting = pending_slices.size();
		end
	end

endmodule

### test/multilevel_feedback_scheduler_test.sv
// Stimulus, reset, clock and verdict for the feedback queue scheduler.
module multilevel_feedback_scheduler_test;
	import mfs_pkg::*;

	localparam int NUM_SLOTS    = 8;
	localparam int NUM_LEVELS   = 3;
	localparam int SETTLE       = (NUM_LEVELS + 1) * NUM_SLOTS + 16;
	localparam int RANDOM_ITEMS = 1550;
	localparam int PHASES       = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  op;
	logic [SLOT_W-1:0]     slot;
	logic [WORK_W-1:0]     burst;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SLOT_W-1:0]     slot_id;
	logic [WORK_W-1:0]     run_units;
	logic [WORK_W-1:0]     remaining_after;
	logic                  completed;
	logic [LEVEL_W-1:0]    level_run;
	logic [TIME_W-1:0]     elapsed;
	logic                  all_done;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [QUANT_W-1:0]    cfg_data;
	int                    error_count;
	int                    open_count;

	bit                    calm;
	int unsigned           items_sent;
	int unsigned           stall_left = 0;

	multilevel_feedback_scheduler #(
		.NUM_SLOTS(NUM_SLOTS),
		.NUM_LEVELS(NUM_LEVELS)
	) DUT (.*);

	mfs_slice_checker #(
		.NUM_SLOTS(NUM_SLOTS),
		.NUM_LEVELS(NUM_LEVELS)
	) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// mostly short gaps, a few long ones, none during a calm stretch
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [WORK_W-1:0] pick_burst();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 75)
			return WORK_W'($urandom_range(1, 120));
		if (r < 95)
			return WORK_W'($urandom_range(121, 4000));
		if (r < 98)
			return WORK_W'($urandom());
		return '1;
	endfunction

	function automatic logic [QUANT_W-1:0] pick_quantum();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return QUANT_W'(1);
		if (r == 2)
			return '1;
		if (r < 8)
			return QUANT_W'($urandom_range(2, 64));
		return QUANT_W'($urandom());
	endfunction

	// hold off the result channel in runs
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	// present one input transaction and hold it until taken
	task automatic put_item(logic o, logic [SLOT_W-1:0] s, logic [WORK_W-1:0] b);
		int unsigned gap;
		in_valid <= 1'b1;
		op       <= o;
		slot     <= s;
		burst    <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_quantum(logic [CFG_IDX_W-1:0] idx, logic [QUANT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// drain outstanding results, then let a silent step finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int unsigned target;
		int unsigned n;
		logic [QUANT_W-1:0] qt;
		logic [QUANT_W-1:0] qm;
		logic [QUANT_W-1:0] qb;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		op         <= OP_LOAD;
		slot       <= '0;
		burst      <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_QUANTUM_TOP;
		cfg_data   <= '0;
		calm       = 1'b1;
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		calm = 1'b0;

		// directed: empty step, extreme and zero bursts, exact and one-over quantum
		put_item(OP_STEP, 3'd0, '0);
		put_item(OP_LOAD, 3'd0, 16'hFFFF);
		put_item(OP_LOAD, 3'd7, 16'd1);
		put_item(OP_LOAD, 3'd3, 16'd0);
		put_item(OP_LOAD, 3'd5, 16'd10);
		put_item(OP_LOAD, 3'd2, 16'h5555);
		put_item(OP_LOAD, 3'd4, 16'hAAAA);
		repeat (12) put_item(OP_STEP, 3'd7, 16'hFFFF);
		put_item(OP_LOAD, 3'd1, 16'd11);
		repeat (3) put_item(OP_STEP, 3'd0, '0);

		// random phases, each under its own quantum setting
		for (int p = 1; p <= PHASES; p++) begin
			wait_idle();
			case (p)
				1: begin
					qt = '0;
					qm = '0;
					qb = '0;
				end
				2: begin
					qt = '1;
					qm = '1;
					qb = '1;
				end
				3: begin
					qt = QUANT_W'(1);
					qm = QUANT_W'(1);
					qb = QUANT_W'(1);
				end
				default: begin
					qt = pick_quantum();
					qm = pick_quantum();
					qb = pick_quantum();
				end
			endcase
			write_quantum(CFG_QUANTUM_TOP, qt);
			write_quantum(CFG_QUANTUM_MIDDLE, qm);
			write_quantum(CFG_QUANTUM_BOTTOM, qb);
			target = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target) begin
				calm = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 4) != 0) begin
					// load a batch of slots, then run slices over them
					n = $urandom_range(1, NUM_SLOTS);
					repeat (n) put_item(OP_LOAD, SLOT_W'($urandom()), pick_burst());
					repeat ($urandom_range(1, 4 * n + 4))
						put_item(OP_STEP, SLOT_W'($urandom()), WORK_W'($urandom()));
				end else begin
					// scattered noise
					repeat ($urandom_range(1, 6))
						put_item(1'($urandom()), SLOT_W'($urandom()), WORK_W'($urandom()));
				end
			end
		end

		calm = 1'b0;
		wait_idle();
		if (error_count == 0 && open_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
